@@ rtl/mof_pkg.sv @@
// ----------------------------------------------------------------------------
// mof_pkg
// Shared widths, defaults and controller-to-datapath command type for the
// median-of-six ADC sample filter.
// ----------------------------------------------------------------------------
package mof_pkg;

  localparam int HIGH_W       = 8;
  localparam int LOW_W        = 2;
  localparam int SAMPLE_W     = HIGH_W + LOW_W;
  localparam int CHAN_W       = 4;
  localparam int GROUP_SIZE_D = 6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic insert;   // insert the accepted sample into the sorted row
    logic first;    // accepted sample opens a group: latch its channel
    logic finish;   // accepted sample closes a group: load the result
  } mof_cmd_t;

endpackage

@@ rtl/mof_ctrl.sv @@
// ----------------------------------------------------------------------------
// mof_ctrl
// Group controller: counts samples in the current group, issues insert,
// first and finish commands, and owns the result valid handshake.
// ----------------------------------------------------------------------------
module mof_ctrl #(
  parameter int GROUP_SIZE = mof_pkg::GROUP_SIZE_D,
  parameter int CNT_W      = $clog2(GROUP_SIZE)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mof_pkg::mof_cmd_t cmd,
  output logic [CNT_W-1:0] fill_count
);
  import mof_pkg::*;

  typedef enum logic [0:0] {
    ST_COLLECT,
    ST_HOLD
  } state_t;

  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(GROUP_SIZE - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             last;

  // Take a sample whenever the result register is empty or being drained
  assign in_ready   = (state_r == ST_COLLECT) || out_ready;
  assign accept     = in_valid && in_ready;
  assign last       = (count_r == LAST_SLOT);
  assign out_valid  = (state_r == ST_HOLD);
  assign fill_count = count_r;

  assign cmd.insert = accept;
  assign cmd.first  = accept && (count_r == '0);
  assign cmd.finish = accept && last;

  // Advance the count and the result state
  always_comb begin
    count_nxt = count_r;
    state_nxt = state_r;
    if (accept) begin
      count_nxt = last ? '0 : count_r + 1'b1;
    end
    case (state_r)
      ST_COLLECT: begin
        if (accept && last) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready && !(accept && last)) state_nxt = ST_COLLECT;
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/mof_dp.sv @@
// ----------------------------------------------------------------------------
// mof_dp
// Datapath: a row of sorted sample cells filled by insertion, the group
// channel latch and the result register (mean of the middle pair).
// ----------------------------------------------------------------------------
module mof_dp #(
  parameter int GROUP_SIZE = mof_pkg::GROUP_SIZE_D,
  parameter int CNT_W      = $clog2(GROUP_SIZE)
) (
  input  logic                         clk,
  input  mof_pkg::mof_cmd_t            cmd,
  input  logic [CNT_W-1:0]             fill_count,
  input  logic [mof_pkg::HIGH_W-1:0]   in_high_byte,
  input  logic [mof_pkg::LOW_W-1:0]    in_low_bits,
  input  logic [mof_pkg::CHAN_W-1:0]   in_channel,
  output logic [mof_pkg::SAMPLE_W-1:0] out_filtered_value,
  output logic [mof_pkg::CHAN_W-1:0]   out_group_channel
);
  import mof_pkg::*;

  localparam int MID_LO = (GROUP_SIZE - 1) / 2;
  localparam int MID_HI = GROUP_SIZE / 2;

  logic [SAMPLE_W-1:0] row_r   [GROUP_SIZE];
  logic [SAMPLE_W-1:0] row_nxt [GROUP_SIZE];
  logic [GROUP_SIZE-1:0] gt;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W:0]   mid_sum;
  logic [CHAN_W-1:0]   chan_r;
  logic [SAMPLE_W-1:0] value_r;
  logic [CHAN_W-1:0]   group_chan_r;

  assign sample = {in_high_byte, in_low_bits};

  // Compare each cell with the new sample; empty cells count as larger
  always_comb begin
    for (int i = 0; i < GROUP_SIZE; i++) begin
      gt[i] = (CNT_W'(i) >= fill_count) || (row_r[i] > sample);
    end
  end

  // Shift larger cells up by one and drop the sample into the gap
  always_comb begin
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (!gt[i]) begin
        row_nxt[i] = row_r[i];
      end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        row_nxt[i] = row_r[(i > 0) ? i - 1 : 0];
      end else begin
        row_nxt[i] = sample;
      end
    end
  end

  assign mid_sum = {1'b0, row_nxt[MID_LO]} + {1'b0, row_nxt[MID_HI]};

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < GROUP_SIZE; i++) row_r[i] <= row_nxt[i];
    end
    if (cmd.first) chan_r <= in_channel;
    // Load the result on the group's last sample
    if (cmd.finish) begin
      value_r      <= mid_sum[SAMPLE_W:1];
      group_chan_r <= cmd.first ? in_channel : chan_r;
    end
  end

  assign out_filtered_value = value_r;
  assign out_group_channel  = group_chan_r;

endmodule

@@ rtl/median_of_six_adc_filter_core.sv @@
// ----------------------------------------------------------------------------
// median_of_six_adc_filter_core
// Result: registered, valid in the cycle after the group's last sample.
// Throughput: one sample per cycle, set by the insertion into the sorted
// cell row; a result not yet taken stalls every input until it is taken.
// Reset: synchronous active-low rst_n drops any partial group and the result.
// ----------------------------------------------------------------------------
module median_of_six_adc_filter_core #(
  parameter int GROUP_SIZE = mof_pkg::GROUP_SIZE_D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mof_pkg::HIGH_W-1:0]   in_high_byte,
  input  logic [mof_pkg::LOW_W-1:0]    in_low_bits,
  input  logic [mof_pkg::CHAN_W-1:0]   in_channel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mof_pkg::SAMPLE_W-1:0] out_filtered_value,
  output logic [mof_pkg::CHAN_W-1:0]   out_group_channel
);
  import mof_pkg::*;

  localparam int CNT_W = $clog2(GROUP_SIZE);

  mof_cmd_t         cmd;
  logic [CNT_W-1:0] fill_count;

  mof_ctrl #(
    .GROUP_SIZE(GROUP_SIZE),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .fill_count(fill_count)
  );

  mof_dp #(
    .GROUP_SIZE(GROUP_SIZE),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .fill_count        (fill_count),
    .in_high_byte      (in_high_byte),
    .in_low_bits       (in_low_bits),
    .in_channel        (in_channel),
    .out_filtered_value(out_filtered_value),
    .out_group_channel (out_group_channel)
  );

endmodule
